@@ rtl/svpwm_duty_from_dq_macros.svh @@
// Assertion macros used by the checker file of the SVPWM duty block.
// Depends on nothing; each macro expects clk and arst_n in scope.
`ifndef SVPWM_DUTY_FROM_DQ_MACROS_SVH
`define SVPWM_DUTY_FROM_DQ_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SVPWM_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Same-cycle implication checked outside reset.
`define SVPWM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/svpwm_pkg.sv @@
// Package for the SVPWM duty block: word types, CORDIC tables and fixed-point constants.
// Depends on nothing; used by the top level, its checkers and the testbench.
package svpwm_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int ANGLE_BITS_DEF  = 16;

	localparam int CORDIC_STEPS = 24;
	localparam int CW           = 33;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// sqrt(3)/2 in Q30, split as K_HI * 2^15 + K_LO.
	localparam logic signed [15:0] K_HI = 16'sd28377;
	localparam logic signed [15:0] K_LO = 16'sd30161;

	localparam int PW        = 29;
	localparam int SW        = 28;
	localparam int QW        = 26;
	localparam int DIV_STEPS = QW;
	localparam int NW        = SW + QW;
	localparam logic [SW-1:0] PHASE_ONE = SW'(1) << 25;

	localparam int PIPE_DEPTH = (CORDIC_STEPS + 1) + 7 + (DIV_STEPS + 1) + 3;

	localparam logic [15:0] DUTY_FULL = 16'd32768;

	typedef struct packed {
		logic signed [15:0] d_voltage;
		logic signed [15:0] q_voltage;
		logic        [15:0] angle;
	} cmd_t;

	typedef struct packed {
		logic [15:0] duty_u;
		logic [15:0] duty_v;
		logic [15:0] duty_w;
		logic        overmodulated;
	} result_t;

endpackage

@@ rtl/svpwm_duty_from_dq.sv @@
// Top level of the SVPWM duty generator: CORDIC, inverse Park/Clarke, span scaling, duty.
// Depends on svpwm_pkg.
//
// A word is taken at every clock edge where start is high; busy is always low, so a new
// word may follow in the very next cycle. Each word produces exactly one result word,
// shown on result with done high for a single cycle. The pipeline holds the 24
// one-iteration CORDIC stages and the 26 one-bit stages of the restoring dividers that
// scale overmodulated phases, plus the input register, seven stages between them, the
// divider setup stage and three stages after; PIPE_DEPTH counts them all.
// The receiver cannot stall the block, and nothing links words, so throughput is one
// word per cycle with no gaps.
module svpwm_duty_from_dq #(
	parameter int SAMPLE_BITS = svpwm_pkg::SAMPLE_BITS_DEF,
	parameter int ANGLE_BITS  = svpwm_pkg::ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  svpwm_pkg::cmd_t    cmd,
	output logic               done,
	output svpwm_pkg::result_t result
);
	import svpwm_pkg::*;

	localparam int TF  = SAMPLE_BITS - 1;
	localparam int TW  = SAMPLE_BITS + 1;
	localparam int TRS = 30 - TF;
	localparam int PS  = 15 + TF - 24;
	localparam int MW  = 16 + TW;
	localparam int AW  = MW + 1;
	localparam int HW  = PW + 32;
	localparam int DW  = PW + 3;
	localparam logic signed [CW-1:0] TR_HALF = CW'(1) <<< (TRS - 1);
	localparam logic signed [CW-1:0] TLIM    = CW'(1) <<< TF;
	localparam logic signed [AW-1:0] PS_HALF = AW'(1) <<< (PS - 1);
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	function automatic logic signed [TW-1:0] clamp_trig(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		r = (v + TR_HALF) >>> TRS;
		if (r > TLIM) r = TLIM;
		if (r < -TLIM) r = -TLIM;
		return TW'(r);
	endfunction

	// The receiver never stalls, so the pipeline always moves.
	assign busy = 1'b0;

	// Angle reduction to within an eighth of a turn of the nearest quadrant.
	logic [ANGLE_BITS-1:0] ang_w;
	logic [31:0]           a32;
	logic [31:0]           a_bias;
	logic [1:0]            quad_w;
	logic [31:0]           z_w;

	assign ang_w  = ANGLE_BITS'({8'd0, cmd.angle});
	assign a32    = {ang_w, {(32 - ANGLE_BITS){1'b0}}};
	assign a_bias = a32 + 32'h20000000;
	assign quad_w = a_bias[31:30];
	assign z_w    = a32 - {quad_w, 30'd0};

	// CORDIC rotation, one iteration per stage.
	logic                 cv_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] cx_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] cy_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] cz_s [0:CORDIC_STEPS];
	logic [1:0]           cq_s [0:CORDIC_STEPS];
	logic signed [15:0]   cd_s [0:CORDIC_STEPS];
	logic signed [15:0]   cvq_s [0:CORDIC_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else begin
			cv_s[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0]  <= CORDIC_GAIN;
		cy_s[0]  <= '0;
		cz_s[0]  <= CW'($signed(z_w));
		cq_s[0]  <= quad_w;
		cd_s[0]  <= cmd.d_voltage;
		cvq_s[0] <= cmd.q_voltage;
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] at;

		assign dx = cy_s[k] >>> k;
		assign dy = cx_s[k] >>> k;
		assign at = CW'(ATAN_TURNS[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[k+1] <= 1'b0;
			end else begin
				cv_s[k+1] <= cv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (!cz_s[k][CW-1]) begin
				cx_s[k+1] <= cx_s[k] - dx;
				cy_s[k+1] <= cy_s[k] + dy;
				cz_s[k+1] <= cz_s[k] - at;
			end else begin
				cx_s[k+1] <= cx_s[k] + dx;
				cy_s[k+1] <= cy_s[k] - dy;
				cz_s[k+1] <= cz_s[k] + at;
			end
			cq_s[k+1]  <= cq_s[k];
			cd_s[k+1]  <= cd_s[k];
			cvq_s[k+1] <= cvq_s[k];
		end
	end

	// Stage 1: round to trig precision and rotate back into the right quadrant.
	logic                 v_s1;
	logic signed [TW-1:0] c_s1, s_s1;
	logic signed [15:0]   d_s1, q_s1;
	logic signed [TW-1:0] rc, rs;

	assign rc = clamp_trig(cx_s[CORDIC_STEPS]);
	assign rs = clamp_trig(cy_s[CORDIC_STEPS]);

	always_ff @(posedge clk) begin
		case (cq_s[CORDIC_STEPS])
			QUAD_0: begin
				c_s1 <= rc;
				s_s1 <= rs;
			end
			QUAD_1: begin
				c_s1 <= -rs;
				s_s1 <= rc;
			end
			QUAD_2: begin
				c_s1 <= -rc;
				s_s1 <= -rs;
			end
			default: begin
				c_s1 <= rs;
				s_s1 <= -rc;
			end
		endcase
		d_s1 <= cd_s[CORDIC_STEPS];
		q_s1 <= cvq_s[CORDIC_STEPS];
	end

	// Stage 2: inverse Park products.
	logic                 v_s2;
	logic signed [MW-1:0] dc_s2, qs_s2, ds_s2, qc_s2;

	always_ff @(posedge clk) begin
		dc_s2 <= d_s1 * c_s1;
		qs_s2 <= q_s1 * s_s1;
		ds_s2 <= d_s1 * s_s1;
		qc_s2 <= q_s1 * c_s1;
	end

	// Stage 3: alpha and beta rounded to Q24.
	logic                 v_s3;
	logic signed [PW-1:0] al_s3, be_s3;
	logic signed [AW-1:0] al_sum, be_sum;

	assign al_sum = (AW'(dc_s2) - AW'(qs_s2) + PS_HALF) >>> PS;
	assign be_sum = (AW'(ds_s2) + AW'(qc_s2) + PS_HALF) >>> PS;

	always_ff @(posedge clk) begin
		al_s3 <= PW'(al_sum);
		be_s3 <= PW'(be_sum);
	end

	// Stage 4: beta times sqrt(3)/2 as two partial products.
	logic                    v_s4;
	logic signed [PW-1:0]    al_s4;
	logic signed [PW+15:0]   phi_s4, plo_s4;

	always_ff @(posedge clk) begin
		al_s4  <= al_s3;
		phi_s4 <= be_s3 * K_HI;
		plo_s4 <= be_s3 * K_LO;
	end

	// Stage 5: combine and round the product to Q25.
	logic                 v_s5;
	logic signed [PW-1:0] al_s5, h_s5;
	logic signed [HW-1:0] h_acc;

	assign h_acc = ((HW'(phi_s4) <<< 15) + HW'(plo_s4) + (HW'(1) <<< 28)) >>> 29;

	always_ff @(posedge clk) begin
		al_s5 <= al_s4;
		h_s5  <= PW'(h_acc);
	end

	// Stage 6: inverse Clarke into three phases.
	logic                 v_s6;
	logic signed [PW-1:0] ph_s6 [3];

	always_ff @(posedge clk) begin
		ph_s6[0] <= al_s5 <<< 1;
		ph_s6[1] <= h_s5 - al_s5;
		ph_s6[2] <= -al_s5 - h_s5;
	end

	// Stage 7: span of the phases and the overmodulation decision.
	logic                 v_s7;
	logic signed [PW-1:0] ph_s7 [3];
	logic [SW-1:0]        span_s7;
	logic                 over_s7;
	logic signed [PW-1:0] mx6, mn6, t6;
	logic [SW-1:0]        span6;

	always_comb begin
		mx6 = ph_s6[0];
		mn6 = ph_s6[0];
		for (int k = 1; k < 3; k++) begin
			if (ph_s6[k] > mx6) mx6 = ph_s6[k];
			if (ph_s6[k] < mn6) mn6 = ph_s6[k];
		end
		t6    = mx6 - mn6;
		span6 = SW'(t6);
	end

	always_ff @(posedge clk) begin
		ph_s7   <= ph_s6;
		span_s7 <= span6;
		over_s7 <= span6 > PHASE_ONE;
	end

	// Restoring dividers: |phase| * 2^25 / span, rounded, one quotient bit per stage.
	logic                 dv_s   [0:DIV_STEPS];
	logic [SW-1:0]        dspan_s [0:DIV_STEPS];
	logic                 dover_s [0:DIV_STEPS];
	logic [SW-1:0]        drem_s [0:DIV_STEPS][3];
	logic [QW-1:0]        dlo_s  [0:DIV_STEPS][3];
	logic [QW-1:0]        dquo_s [0:DIV_STEPS][3];
	logic                 dneg_s [0:DIV_STEPS][3];
	logic signed [PW-1:0] dph_s  [0:DIV_STEPS][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else begin
			dv_s[0] <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		dspan_s[0] <= span_s7;
		dover_s[0] <= over_s7;
	end

	for (genvar l = 0; l < 3; l++) begin : g_div_entry
		logic signed [PW-1:0] amag;
		logic [SW-1:0]        mag;
		logic [NW-1:0]        num;

		assign amag = ph_s7[l][PW-1] ? -ph_s7[l] : ph_s7[l];
		assign mag  = SW'(amag);
		assign num  = {mag, 26'd0} / 2 + NW'(span_s7 >> 1);

		always_ff @(posedge clk) begin
			drem_s[0][l] <= num[NW-1:QW];
			dlo_s[0][l]  <= num[QW-1:0];
			dquo_s[0][l] <= '0;
			dneg_s[0][l] <= ph_s7[l][PW-1];
			dph_s[0][l]  <= ph_s7[l];
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j+1] <= 1'b0;
			end else begin
				dv_s[j+1] <= dv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			dspan_s[j+1] <= dspan_s[j];
			dover_s[j+1] <= dover_s[j];
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [SW:0] r2;
			logic        ge;

			assign r2 = {drem_s[j][l], dlo_s[j][l][QW-1]};
			assign ge = r2 >= {1'b0, dspan_s[j]};

			always_ff @(posedge clk) begin
				drem_s[j+1][l] <= ge ? SW'(r2 - {1'b0, dspan_s[j]}) : SW'(r2);
				dlo_s[j+1][l]  <= dlo_s[j][l] << 1;
				dquo_s[j+1][l] <= {dquo_s[j][l][QW-2:0], ge};
				dneg_s[j+1][l] <= dneg_s[j][l];
				dph_s[j+1][l]  <= dph_s[j][l];
			end
		end
	end

	// Stage 8: pick the scaled or the plain phases.
	logic                 v_s8;
	logic                 over_s8;
	logic signed [PW-1:0] p_s8 [3];

	for (genvar l = 0; l < 3; l++) begin : g_sel
		logic signed [PW-1:0] qv;

		assign qv = PW'(dquo_s[DIV_STEPS][l]);

		always_ff @(posedge clk) begin
			if (dover_s[DIV_STEPS]) begin
				p_s8[l] <= dneg_s[DIV_STEPS][l] ? -qv : qv;
			end else begin
				p_s8[l] <= dph_s[DIV_STEPS][l];
			end
		end
	end

	always_ff @(posedge clk) begin
		over_s8 <= dover_s[DIV_STEPS];
	end

	// Stage 9: common mode as max plus min.
	logic                 v_s9;
	logic                 over_s9;
	logic signed [PW-1:0] p_s9 [3];
	logic signed [PW:0]   sum_s9;
	logic signed [PW-1:0] mx8, mn8;

	always_comb begin
		mx8 = p_s8[0];
		mn8 = p_s8[0];
		for (int k = 1; k < 3; k++) begin
			if (p_s8[k] > mx8) mx8 = p_s8[k];
			if (p_s8[k] < mn8) mn8 = p_s8[k];
		end
	end

	always_ff @(posedge clk) begin
		over_s9 <= over_s8;
		p_s9    <= p_s8;
		sum_s9  <= (PW+1)'(mx8) + (PW+1)'(mn8);
	end

	// Stage 10: duty = 0.5 + phase - common mode, rounded to Q15 and clamped.
	logic [15:0] duty_w [3];

	for (genvar l = 0; l < 3; l++) begin : g_duty
		logic signed [DW-1:0] d26;
		logic signed [DW-1:0] d15;

		assign d26 = DW'(PHASE_ONE) + (DW'(p_s9[l]) <<< 1) - DW'(sum_s9);
		assign d15 = (d26 + DW'(1024)) >>> 11;

		always_comb begin
			if (d15 < 0) begin
				duty_w[l] = '0;
			end else if (d15 > DW'(DUTY_FULL)) begin
				duty_w[l] = DUTY_FULL;
			end else begin
				duty_w[l] = 16'(d15);
			end
		end
	end

	always_ff @(posedge clk) begin
		result.duty_u        <= duty_w[0];
		result.duty_v        <= duty_w[1];
		result.duty_w        <= duty_w[2];
		result.overmodulated <= over_s9;
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= cv_s[CORDIC_STEPS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= dv_s[DIV_STEPS];
			v_s9 <= v_s8;
			done <= v_s9;
		end
	end

endmodule

@@ rtl/svpwm_chk.sv @@
// Port-level checker for the SVPWM duty block, bound to the top level.
// Depends on svpwm_pkg and svpwm_duty_from_dq_macros.svh.
`include "svpwm_duty_from_dq_macros.svh"

module svpwm_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input svpwm_pkg::cmd_t    cmd,
	input logic               done,
	input svpwm_pkg::result_t result
);
	import svpwm_pkg::*;

	// The block never pushes back on the sender.
	`SVPWM_ASSERT(a_never_busy, !busy, "busy raised")

	// Every result word comes from a word taken a fixed pipeline depth earlier.
	`SVPWM_ASSERT_IMP(a_latency, done, $past(start, PIPE_DEPTH), "result without a matching word")

	// Duties stay within zero to full scale.
	`SVPWM_ASSERT_IMP(a_range, done, (result.duty_u <= DUTY_FULL) && (result.duty_v <= DUTY_FULL) && (result.duty_w <= DUTY_FULL), "duty out of range")

endmodule

bind svpwm_duty_from_dq svpwm_chk u_svpwm_chk (.*);

@@ sim/svpwm_duty_checker.sv @@
// Scoreboard for the SVPWM duty block: predicts each result word from the command word.
// Depends on svpwm_pkg; the predictor is an independent fixed-point model of the block.
`timescale 1ns / 1ps
module svpwm_duty_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  svpwm_pkg::cmd_t    cmd,
	input  logic               done,
	input  svpwm_pkg::result_t result,
	output int                 fail_count,
	output int                 pending
);
	import svpwm_pkg::*;

	localparam int TRIG_FRAC = 15;

	result_t duty_queue[$];
	int mismatches;

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rnd_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp_unit(longint v);
		longint lim;
		lim = longint'(1) << TRIG_FRAC;
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint span_scale(longint p, longint span);
		longint mag, q;
		mag = (p < 0 ? -p : p) * (longint'(1) << 25);
		q = (mag + span / 2) / span;
		return p < 0 ? -q : q;
	endfunction

	function automatic logic [15:0] duty_of(longint p, longint sum_mm);
		longint d;
		d = rnd_shift((longint'(1) << 25) + 2 * p - sum_mm, 11);
		if (d < 0) d = 0;
		if (d > 32768) d = 32768;
		return 16'(d);
	endfunction

	function automatic result_t predict_duty(cmd_t c);
		result_t r;
		longint a32, quad, z, x, y, dx, dy, cs, sn, s, co;
		longint dv, qv, alpha, beta, h, mx, mn, span;
		longint ph[3];
		a32 = longint'(c.angle) << 16;
		quad = ((a32 + 64'h20000000) >> 30) & 3;
		z = a32 - quad * 64'h40000000;
		// Signed compare: z is negative just below a quadrant boundary.
		if (z >= 64'sh80000000) z -= 64'h100000000;
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
			end
		end
		cs = clamp_unit(rnd_shift(x, 30 - TRIG_FRAC));
		sn = clamp_unit(rnd_shift(y, 30 - TRIG_FRAC));
		case (quad)
			0: begin co = cs;  s = sn;  end
			1: begin co = -sn; s = cs;  end
			2: begin co = -cs; s = -sn; end
			default: begin co = sn; s = -cs; end
		endcase
		dv = longint'(c.d_voltage);
		qv = longint'(c.q_voltage);
		alpha = rnd_shift(dv * co - qv * s, 6);
		beta  = rnd_shift(dv * s + qv * co, 6);
		h = rnd_shift(beta * 929887697, 29);
		ph[0] = 2 * alpha;
		ph[1] = -alpha + h;
		ph[2] = -alpha - h;
		mx = ph[0];
		mn = ph[0];
		for (int k = 1; k < 3; k++) begin
			if (ph[k] > mx) mx = ph[k];
			if (ph[k] < mn) mn = ph[k];
		end
		span = mx - mn;
		r.overmodulated = span > (longint'(1) << 25);
		if (r.overmodulated) begin
			for (int k = 0; k < 3; k++) ph[k] = span_scale(ph[k], span);
			mx = span_scale(mx, span);
			mn = span_scale(mn, span);
		end
		r.duty_u = duty_of(ph[0], mx + mn);
		r.duty_v = duty_of(ph[1], mx + mn);
		r.duty_w = duty_of(ph[2], mx + mn);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			duty_queue.delete();
			mismatches = 0;
		end else begin
			if (done) begin
				if (duty_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result word %h", result);
				end else begin
					want = duty_queue.pop_front();
					if (result.duty_u !== want.duty_u || result.duty_v !== want.duty_v ||
							result.duty_w !== want.duty_w ||
							result.overmodulated !== want.overmodulated) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Duty mismatch: expected u=%0d v=%0d w=%0d ov=%0b, got u=%0d v=%0d w=%0d ov=%0b",
								want.duty_u, want.duty_v, want.duty_w, want.overmodulated,
								result.duty_u, result.duty_v, result.duty_w,
								result.overmodulated);
					end
				end
			end
			if (start && !busy)
				duty_queue.push_back(predict_duty(cmd));
		end
	end

	assign fail_count = mismatches;
	assign pending = duty_queue.size();
endmodule

@@ sim/testbench.sv @@
// Top of the SVPWM duty testbench: clock, reset, command stimulus and verdict.
// Depends on svpwm_pkg, svpwm_duty_from_dq and svpwm_duty_checker.
`timescale 1ns / 1ps
module testbench;
	import svpwm_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	cmd_t    cmd = '0;
	logic    done;
	result_t result;
	int      fail_count;
	int      pending;
	int      cycles = 0;
	int      idle_pct = 0;

	// The clock has period 10 ns.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A watchdog that ends the run far beyond the slowest correct run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("Verification failed");
			$finish;
		end
	end

	svpwm_duty_from_dq i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	svpwm_duty_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .fail_count(fail_count), .pending(pending)
	);

	// Present one command word and hold it until the block takes it. Idle gaps come
	// first, drawn against the current idle percentage, so gaps land on any stage.
	task automatic send_word(input logic [15:0] dv, input logic [15:0] qv,
			input logic [15:0] ang);
		while ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd.d_voltage <= dv;
		cmd.q_voltage <= qv;
		cmd.angle <= ang;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// Random voltage: mostly full range, sometimes small or at a rail.
	function automatic logic [15:0] rand_volt();
		case ($urandom_range(3, 0))
			0: return 16'($urandom_range(4000, 0)) - 16'd2000;
			1: return $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom());
		endcase
	endfunction

	initial begin
		logic [15:0] rails[4];
		rails = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words: voltage rails at the quadrant and octant angles, including
		// commands deep into overmodulation where duties saturate.
		for (int k = 0; k < 4; k++)
			send_word(rails[k], rails[3 - k], 16'(k) << 14);
		for (int k = 0; k < 8; k++)
			send_word(16'h7FFF, 16'h7FFF, (16'(k) << 13) | (k[0] ? 16'h0 : 16'h1));
		send_word(16'h0000, 16'h0000, 16'hFFFF);
		send_word(16'h8000, 16'h8000, 16'h2000);
		send_word(16'h4000, 16'h0000, 16'h5555);
		send_word(16'h0000, 16'h4000, 16'hAAAA);
		send_word(16'h2000, 16'hE000, 16'h1FFF);
		send_word(16'h49E7, 16'h0000, 16'h0000);

		// Random words across four idling phases.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: idle_pct = 0;
				1: idle_pct = 76;
				2: idle_pct = 0;
				default: idle_pct = 31;
			endcase
			for (int n = 0; n < 460; n++)
				send_word(rand_volt(), rand_volt(), 16'($urandom()));
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (70) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
